// ----- rtl/core/ydc_pkg.sv -----
package ydc_pkg;

  localparam int PixW  = 8;
  localparam int TermW = 26;
  localparam int SumW  = 27;
  localparam int FracW = 16;

  localparam logic [PixW-1:0] ChromaMid = 8'd128;
  localparam logic [PixW-1:0] DimMul    = 8'd220;
  localparam logic [PixW-1:0] PixMax    = 8'd255;

  localparam logic signed [TermW-1:0] CrToR = 26'sd89830;
  localparam logic signed [TermW-1:0] CrToG = 26'sd45744;
  localparam logic signed [TermW-1:0] CbToG = 26'sd22127;
  localparam logic signed [TermW-1:0] CbToB = 26'sd113537;

  typedef struct packed {
    logic [PixW-1:0] luma_first;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] luma_second;
    logic [PixW-1:0] chroma_red;
  } ydc_in_t;

  typedef struct packed {
    logic [PixW-1:0] red_first;
    logic [PixW-1:0] green_first;
    logic [PixW-1:0] blue_first;
    logic [PixW-1:0] red_second;
    logic [PixW-1:0] green_second;
    logic [PixW-1:0] blue_second;
  } ydc_out_t;

  typedef struct packed {
    logic signed [TermW-1:0] red;
    logic signed [TermW-1:0] green;
    logic signed [TermW-1:0] blue;
  } ydc_chroma_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } ydc_rgb_t;

endpackage

// ----- rtl/core/ydc_pixel.sv -----
module ydc_pixel
  import ydc_pkg::*;
(
  input  logic [PixW-1:0] luma,
  input  ydc_chroma_t     chroma,
  output ydc_rgb_t        rgb
);

  function automatic logic [PixW-1:0] floor_clamp(input logic [PixW-1:0] y,
                                                  input logic signed [TermW-1:0] term);
    logic signed [SumW-1:0] sum;
    logic [PixW-1:0]        res;
    sum = $signed({{(SumW-PixW-FracW){1'b0}}, y, {FracW{1'b0}}}) + SumW'(term);
    if (sum[SumW-1]) begin
      res = '0;
    end else if (sum[SumW-2:FracW+PixW] != '0) begin
      res = PixMax;
    end else begin
      res = sum[FracW+PixW-1:FracW];
    end
    return res;
  endfunction

  assign rgb.red   = floor_clamp(luma, chroma.red);
  assign rgb.green = floor_clamp(luma, chroma.green);
  assign rgb.blue  = floor_clamp(luma, chroma.blue);

endmodule

// ----- rtl/core/yuyv_to_rgb_dimmed_converter.sv -----
// YUYV 4:2:2 to RGB888 converter with a fixed 220/256 dimming.
// Input channel: in_valid, in_stall, in_data carries one packed word with
// the bytes Y0, U, Y1 and V. Output channel: out_valid, out_stall, out_data
// carries two RGB pixels that share the U and V of the word.
// The datapath is a four-stage pipeline: input register, chroma products,
// sum with floor and clamp, and the dimming multiply into the output register.
// An accepted request passes the input, chroma, pixel and output registers in order and then shows on out_data.
// One request is accepted every cycle while the receiver does not stall.
// When out_stall is high, the pipeline compresses into its empty stages and
// then holds; in_stall rises only when the input stage is full and cannot move.
// No request is lost or repeated during a stall.
// A synchronous reset with rst_n low empties every stage; out_valid is low
// and in_stall is low after reset.
module yuyv_to_rgb_dimmed_converter
  import ydc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ydc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ydc_out_t out_data
);

  logic valid_a_r, valid_b_r, valid_c_r, valid_d_r;
  logic en_a, en_b, en_c, en_d;

  ydc_in_t                 in_r;
  logic [PixW-1:0]         y0_b_r, y1_b_r;
  ydc_chroma_t             chroma_nxt, chroma_r;
  ydc_rgb_t                pix0_nxt, pix1_nxt, pix0_r, pix1_r;
  ydc_out_t                out_nxt, out_r;
  logic signed [PixW:0]    d_sig, e_sig;

  assign en_d = !valid_d_r || !out_stall;
  assign en_c = !valid_c_r || en_d;
  assign en_b = !valid_b_r || en_c;
  assign en_a = !valid_a_r || en_b;

  assign in_stall  = !en_a;
  assign out_valid = valid_d_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else begin
      if (en_a) valid_a_r <= in_valid;
      if (en_b) valid_b_r <= valid_a_r;
      if (en_c) valid_c_r <= valid_b_r;
      if (en_d) valid_d_r <= valid_c_r;
    end
  end

  assign d_sig = $signed({1'b0, in_r.chroma_red}) - $signed({1'b0, ChromaMid});
  assign e_sig = $signed({1'b0, in_r.chroma_blue}) - $signed({1'b0, ChromaMid});

  always_comb begin
    chroma_nxt.red   = TermW'(d_sig) * CrToR;
    chroma_nxt.green = -(TermW'(d_sig) * CrToG) - (TermW'(e_sig) * CbToG);
    chroma_nxt.blue  = TermW'(e_sig) * CbToB;
  end

  ydc_pixel u_pixel_first (
    .luma   (y0_b_r),
    .chroma (chroma_r),
    .rgb    (pix0_nxt)
  );

  ydc_pixel u_pixel_second (
    .luma   (y1_b_r),
    .chroma (chroma_r),
    .rgb    (pix1_nxt)
  );

  function automatic logic [PixW-1:0] dim(input logic [PixW-1:0] x);
    logic [2*PixW-1:0] prod;
    prod = x * DimMul;
    return prod[2*PixW-1:PixW];
  endfunction

  always_comb begin
    out_nxt.red_first    = dim(pix0_r.red);
    out_nxt.green_first  = dim(pix0_r.green);
    out_nxt.blue_first   = dim(pix0_r.blue);
    out_nxt.red_second   = dim(pix1_r.red);
    out_nxt.green_second = dim(pix1_r.green);
    out_nxt.blue_second  = dim(pix1_r.blue);
  end

  always_ff @(posedge clk) begin
    if (en_a) in_r <= in_data;
    if (en_b) begin
      y0_b_r   <= in_r.luma_first;
      y1_b_r   <= in_r.luma_second;
      chroma_r <= chroma_nxt;
    end
    if (en_c) begin
      pix0_r <= pix0_nxt;
      pix1_r <= pix1_nxt;
    end
    if (en_d) out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_stall_without_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("in_stall high while the receiver accepts");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (valid_a_r && valid_b_r && valid_c_r && valid_d_r))
    else $error("in_stall high with an empty pipeline stage");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_dimmed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_first <= 8'd219 && out_data.green_first <= 8'd219 &&
                   out_data.blue_first <= 8'd219 && out_data.red_second <= 8'd219 &&
                   out_data.green_second <= 8'd219 && out_data.blue_second <= 8'd219))
    else $error("dimmed output above 219");
`endif

endmodule

// ----- verif/yuyv_to_rgb_dimmed_converter_test.sv -----
module yuyv_to_rgb_dimmed_converter_test
  import ydc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RedFromCr   = 89830;
  localparam longint GreenFromCr = 45744;
  localparam longint GreenFromCb = 22127;
  localparam longint BlueFromCb  = 113537;
  localparam longint ChromaBias  = 128;
  localparam longint DimGain     = 220;
  localparam int IdlePercent     = 11;
  localparam int HoldCycles      = 64;
  localparam int WatchdogLimit   = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ydc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ydc_out_t out_data;

  ydc_out_t pixel_pair_q[$];
  int       mismatch_count;
  int       quiet_cycles;
  bit       sender_idle_on;
  bit       receiver_stall_on;
  bit       hold_req;

  yuyv_to_rgb_dimmed_converter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [7:0] dim_channel(input longint q16);
    longint level;
    level = q16 >>> 16;
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    return 8'((level * DimGain) >> 8);
  endfunction

  function automatic ydc_out_t predict_pixel_pair(input ydc_in_t word);
    ydc_out_t pair;
    longint cb;
    longint cr;
    longint y0;
    longint y1;
    cb = longint'(word.chroma_blue) - ChromaBias;
    cr = longint'(word.chroma_red) - ChromaBias;
    y0 = longint'(word.luma_first) * 65536;
    y1 = longint'(word.luma_second) * 65536;
    pair.red_first    = dim_channel(y0 + RedFromCr * cr);
    pair.green_first  = dim_channel(y0 - GreenFromCr * cr - GreenFromCb * cb);
    pair.blue_first   = dim_channel(y0 + BlueFromCb * cb);
    pair.red_second   = dim_channel(y1 + RedFromCr * cr);
    pair.green_second = dim_channel(y1 - GreenFromCr * cr - GreenFromCb * cb);
    pair.blue_second  = dim_channel(y1 + BlueFromCb * cb);
    return pair;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[6];
    corner = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254};
    if ($urandom_range(99) < 20) return corner[$urandom_range(5)];
    return 8'($urandom);
  endfunction

  function automatic ydc_in_t random_word();
    ydc_in_t word;
    word.luma_first  = pick_byte();
    word.chroma_blue = pick_byte();
    word.luma_second = pick_byte();
    word.chroma_red  = pick_byte();
    return word;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_word(input ydc_in_t word);
    while (sender_idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall);
    pixel_pair_q.push_back(predict_pixel_pair(word));
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pixel_pair_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_corners();
    ydc_in_t words[$];
    words.push_back('{8'd0,   8'd128, 8'd0,   8'd128});
    words.push_back('{8'd255, 8'd128, 8'd255, 8'd128});
    words.push_back('{8'd0,   8'd0,   8'd255, 8'd0});
    words.push_back('{8'd255, 8'd255, 8'd0,   8'd255});
    words.push_back('{8'd0,   8'd255, 8'd255, 8'd0});
    words.push_back('{8'd255, 8'd0,   8'd0,   8'd255});
    words.push_back('{8'd128, 8'd0,   8'd128, 8'd128});
    words.push_back('{8'd128, 8'd255, 8'd128, 8'd128});
    words.push_back('{8'd128, 8'd128, 8'd128, 8'd0});
    words.push_back('{8'd128, 8'd128, 8'd128, 8'd255});
    words.push_back('{8'd16,  8'd128, 8'd235, 8'd128});
    words.push_back('{8'd1,   8'd127, 8'd254, 8'd129});
    words.push_back('{8'd200, 8'd60,  8'd50,  8'd220});
    words.push_back('{8'd30,  8'd240, 8'd230, 8'd16});
    words.push_back('{8'd170, 8'd85,  8'd85,  8'd170});
    words.push_back('{8'd85,  8'd170, 8'd170, 8'd85});
    words.push_back('{8'd240, 8'd16,  8'd16,  8'd16});
    words.push_back('{8'd16,  8'd240, 8'd240, 8'd240});
    words.push_back('{8'd100, 8'd129, 8'd100, 8'd127});
    words.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    words.push_back('{8'd0,   8'd0,   8'd0,   8'd0});
    foreach (words[i]) send_word(words[i]);
  endtask

  task automatic test_random_with_idling();
    repeat (650) send_word(random_word());
  endtask

  task automatic test_back_to_back();
    sender_idle_on    = 1'b0;
    receiver_stall_on = 1'b0;
    repeat (200) send_word(random_word());
    sender_idle_on    = 1'b1;
    receiver_stall_on = 1'b1;
  endtask

  task automatic test_receiver_hold();
    sender_idle_on = 1'b0;
    hold_req       = 1'b1;
    repeat (60) send_word(random_word());
    sender_idle_on = 1'b1;
  endtask

  task automatic test_pause_for_drain();
    repeat (100) send_word(random_word());
    pause_until_drained();
    repeat (100) send_word(random_word());
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        for (int n = 0; n < HoldCycles; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= receiver_stall_on && ($urandom_range(99) < IdlePercent);
    end
  end

  always @(posedge clk) begin
    ydc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_pair_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data), 0);
      end else begin
        want = pixel_pair_q.pop_front();
        if (out_data.red_first != want.red_first)
          report_mismatch("red_first", out_data.red_first, want.red_first);
        if (out_data.green_first != want.green_first)
          report_mismatch("green_first", out_data.green_first, want.green_first);
        if (out_data.blue_first != want.blue_first)
          report_mismatch("blue_first", out_data.blue_first, want.blue_first);
        if (out_data.red_second != want.red_second)
          report_mismatch("red_second", out_data.red_second, want.red_second);
        if (out_data.green_second != want.green_second)
          report_mismatch("green_second", out_data.green_second, want.green_second);
        if (out_data.blue_second != want.blue_second)
          report_mismatch("blue_second", out_data.blue_second, want.blue_second);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data           = '0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    sender_idle_on    = 1'b1;
    receiver_stall_on = 1'b1;
    hold_req          = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_corners();
    test_random_with_idling();
    test_back_to_back();
    test_receiver_hold();
    test_pause_for_drain();
    in_valid <= 1'b0;
    while (pixel_pair_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ydc_pkg.sv
rtl/core/ydc_pixel.sv
rtl/core/yuyv_to_rgb_dimmed_converter.sv
verif/yuyv_to_rgb_dimmed_converter_test.sv
